// ----- design/rmrl_pkg.sv -----
package rmrl_pkg;

  // Register indexes of the configuration channel
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataWidth = 24;

  localparam logic [CfgIdxWidth-1:0] CFG_MIN_WRITE_INTERVAL   = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SMALL_CHANGE_REFRESH = 8'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_MIN_USEFUL_DELTA     = 8'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_AUDIO_TIMEOUT        = 8'd3;

  // Register reset values
  localparam logic [19:0] MIN_WRITE_INTERVAL_RST   = 20'd5000;
  localparam logic [19:0] SMALL_CHANGE_REFRESH_RST = 20'd25000;
  localparam logic [7:0]  MIN_USEFUL_DELTA_RST     = 8'd3;
  localparam logic [23:0] AUDIO_TIMEOUT_RST        = 24'd100000;

  // Event kinds
  typedef enum logic {
    OP_AUDIO = 1'b0,
    OP_OTHER = 1'b1
  } op_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  audio_low;
    logic [7:0]  audio_high;
    logic        rumble_request;
    logic [7:0]  rumble_low;
    logic [7:0]  rumble_high;
    logic [31:0] now_time;
  } evt_t;

  typedef struct packed {
    logic [7:0] write_low;
    logic [7:0] write_high;
  } res_t;

  typedef struct packed {
    logic [19:0] min_write_interval;
    logic [19:0] small_change_refresh;
    logic [7:0]  min_useful_delta;
    logic [23:0] audio_timeout;
  } cfg_t;

endpackage

// ----- design/rmrl_stream_if.sv -----
interface rmrl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/rmrl_cfg_if.sv -----
interface rmrl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rmrl_pkg::CfgIdxWidth-1:0]  index;
  logic [rmrl_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/rumble_mix_rate_limiter_top.sv -----
// A write, if any, is registered in the result register as its event leaves the event register.
// Throughput: one event per cycle while the receiver keeps up; an event that must write waits
// in the event register while the previous write is still untransferred, stalling the input.
// The whole mix and rate-limit decision is one pass of compare logic on the event register.
// Reset (rst_ni, asynchronous, active low) clears all levels, times and flags and loads
// the register defaults; no event is held and no write is shown after reset.
module rumble_mix_rate_limiter_top #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmrl_cfg_if.sink      cfg_i,
  rmrl_stream_if.sink   evt_i,
  rmrl_stream_if.source res_o
);
  import rmrl_pkg::*;

  localparam int unsigned CmpWidth = (TIME_WIDTH > 24) ? TIME_WIDTH : 24;

  cfg_t cfg;

  rmrl_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Event register
  logic evt_v_q;
  evt_t evt_q;

  // Result register
  logic res_v_q;
  res_t res_q;

  // Mixer and limiter state
  logic [7:0]            aud_lo_q, aud_hi_q, game_lo_q, game_hi_q;
  logic [7:0]            aud_lo_d, aud_hi_d, game_lo_d, game_hi_d;
  logic [7:0]            sent_lo_q, sent_hi_q;
  logic                  sent_valid_q;
  logic [TIME_WIDTH-1:0] last_write_q, last_audio_q, last_audio_d;
  logic                  audio_seen_q, audio_seen_d;
  logic                  pending_q, pending_d;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] audio_elapsed, write_elapsed;
  logic                  timed_out, changed, force_write, proceed;
  logic [7:0]            want_lo, want_hi, diff_lo, diff_hi;
  logic                  dup, prev_zero, want_zero, too_soon, small_chg, hold_back;
  logic                  emit, advance, res_free;

  assign now = TIME_WIDTH'(evt_q.now_time);

  // Handshake: the event register moves on when its write, if any, has a place
  assign res_free    = !res_v_q || res_o.ready;
  assign advance     = evt_v_q && (!emit || res_free);
  assign evt_i.ready = !evt_v_q || advance;

  // Update the audio and game levels
  always_comb begin
    audio_elapsed = now - last_audio_q;
    timed_out     = audio_seen_q && ((aud_lo_q != 8'd0) || (aud_hi_q != 8'd0)) &&
                    (CmpWidth'(audio_elapsed) >= CmpWidth'(cfg.audio_timeout));
    aud_lo_d      = aud_lo_q;
    aud_hi_d      = aud_hi_q;
    game_lo_d     = game_lo_q;
    game_hi_d     = game_hi_q;
    last_audio_d  = last_audio_q;
    audio_seen_d  = audio_seen_q;
    changed       = 1'b0;
    force_write   = 1'b0;
    if (evt_q.operation == OP_AUDIO) begin
      changed      = (evt_q.audio_low != aud_lo_q) || (evt_q.audio_high != aud_hi_q);
      aud_lo_d     = evt_q.audio_low;
      aud_hi_d     = evt_q.audio_high;
      last_audio_d = now;
      audio_seen_d = 1'b1;
    end else begin
      if (timed_out) begin
        aud_lo_d    = 8'd0;
        aud_hi_d    = 8'd0;
        changed     = 1'b1;
        force_write = 1'b1;
      end
      if (evt_q.rumble_request) begin
        if ((evt_q.rumble_low != game_lo_q) || (evt_q.rumble_high != game_hi_q)) begin
          changed = 1'b1;
        end
        game_lo_d   = evt_q.rumble_low;
        game_hi_d   = evt_q.rumble_high;
        force_write = 1'b1;
      end
    end
  end

  // Mix and decide whether to write, drop or hold back
  always_comb begin
    want_lo       = (game_lo_d > aud_lo_d) ? game_lo_d : aud_lo_d;
    want_hi       = (game_hi_d > aud_hi_d) ? game_hi_d : aud_hi_d;
    proceed       = changed || pending_q;
    dup           = sent_valid_q && (sent_lo_q == want_lo) && (sent_hi_q == want_hi);
    prev_zero     = (sent_lo_q == 8'd0) && (sent_hi_q == 8'd0);
    want_zero     = (want_lo == 8'd0) && (want_hi == 8'd0);
    write_elapsed = now - last_write_q;
    diff_lo       = (sent_lo_q > want_lo) ? sent_lo_q - want_lo : want_lo - sent_lo_q;
    diff_hi       = (sent_hi_q > want_hi) ? sent_hi_q - want_hi : want_hi - sent_hi_q;
    too_soon      = CmpWidth'(write_elapsed) < CmpWidth'(cfg.min_write_interval);
    small_chg     = (diff_lo < cfg.min_useful_delta) && (diff_hi < cfg.min_useful_delta) &&
                    (CmpWidth'(write_elapsed) < CmpWidth'(cfg.small_change_refresh));
    hold_back     = !force_write && (prev_zero == want_zero) && (too_soon || small_chg);
    emit          = proceed && !dup && !hold_back;
    pending_d     = pending_q;
    if (proceed) begin
      pending_d = !dup && hold_back;
    end
  end

  // Event register: load on transfer, drop when processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_v_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_v_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q <= evt_i.payload;
    end
  end

  // Commit state when the event leaves the event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aud_lo_q     <= '0;
      aud_hi_q     <= '0;
      game_lo_q    <= '0;
      game_hi_q    <= '0;
      sent_lo_q    <= '0;
      sent_hi_q    <= '0;
      sent_valid_q <= 1'b0;
      last_write_q <= '0;
      last_audio_q <= '0;
      audio_seen_q <= 1'b0;
      pending_q    <= 1'b0;
    end else if (advance) begin
      aud_lo_q     <= aud_lo_d;
      aud_hi_q     <= aud_hi_d;
      game_lo_q    <= game_lo_d;
      game_hi_q    <= game_hi_d;
      last_audio_q <= last_audio_d;
      audio_seen_q <= audio_seen_d;
      pending_q    <= pending_d;
      if (emit) begin
        sent_lo_q    <= want_lo;
        sent_hi_q    <= want_hi;
        sent_valid_q <= 1'b1;
        last_write_q <= now;
      end
    end
  end

  // Result register: hold until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (advance && emit) begin
      res_v_q <= 1'b1;
    end else if (res_o.ready) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q.write_low  <= want_lo;
      res_q.write_high <= want_hi;
    end
  end

  assign res_o.valid   = res_v_q;
  assign res_o.payload = res_q;

  // A committed write always marks the levels as sent and clears pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> sent_valid_q && !pending_q)
    else $error("write committed without updating sent state");

  // Never write the same levels twice in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && sent_valid_q |-> !((want_lo == sent_lo_q) && (want_hi == sent_hi_q)))
    else $error("repeated write emitted");

  // A write leaving the event register always finds the result register free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |-> res_free)
    else $error("result register overwritten");

  // A blocked event keeps the input side stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_v_q && !advance |-> !evt_i.ready)
    else $error("input taken while event register blocked");

  // A held-back write is reported next cycle as pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && proceed && !dup && hold_back |=> pending_q)
    else $error("held-back write not marked pending");

endmodule

// ----- design/rmrl_cfg_regs.sv -----
module rmrl_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  rmrl_cfg_if.sink       cfg_i,
  output rmrl_pkg::cfg_t cfg_o
);
  import rmrl_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Always take a write; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MIN_WRITE_INTERVAL:   cfg_d.min_write_interval   = cfg_i.data[19:0];
        CFG_SMALL_CHANGE_REFRESH: cfg_d.small_change_refresh = cfg_i.data[19:0];
        CFG_MIN_USEFUL_DELTA:     cfg_d.min_useful_delta     = cfg_i.data[7:0];
        CFG_AUDIO_TIMEOUT:        cfg_d.audio_timeout        = cfg_i.data[23:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_write_interval   <= MIN_WRITE_INTERVAL_RST;
      cfg_q.small_change_refresh <= SMALL_CHANGE_REFRESH_RST;
      cfg_q.min_useful_delta     <= MIN_USEFUL_DELTA_RST;
      cfg_q.audio_timeout        <= AUDIO_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- tb/sv/rmrl_mix_checker.sv -----
`timescale 1ns / 1ps

module rmrl_mix_checker
  import rmrl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    evt_valid_i,
  input  logic                    evt_ready_i,
  input  evt_t                    evt_i,
  input  logic                    res_valid_i,
  input  logic                    res_ready_i,
  input  res_t                    res_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             writes_due_o
);

  // Shadow copy of the registers and of the mixing state
  cfg_t        limits;
  logic [7:0]  audio_low_q;
  logic [7:0]  audio_high_q;
  logic [7:0]  game_low_q;
  logic [7:0]  game_high_q;
  logic [7:0]  sent_low_q;
  logic [7:0]  sent_high_q;
  logic        sent_any_q;
  logic        audio_heard_q;
  logic        write_held_q;
  logic [31:0] last_write_us;
  logic [31:0] last_audio_us;
  res_t        expected_writes[$];

  function automatic logic [7:0] level_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Work out whether an event leads to a motor write, and which levels it carries
  function automatic bit predict_motor_write(input evt_t ev, output res_t wr);
    logic        changed;
    logic        forced;
    logic        small_step;
    logic [7:0]  want_low;
    logic [7:0]  want_high;
    logic [31:0] elapsed;
    changed = 1'b0;
    forced  = 1'b0;
    wr      = '0;
    if (ev.operation == OP_AUDIO) begin
      changed       = (ev.audio_low != audio_low_q) || (ev.audio_high != audio_high_q);
      audio_low_q   = ev.audio_low;
      audio_high_q  = ev.audio_high;
      last_audio_us = ev.now_time;
      audio_heard_q = 1'b1;
    end else begin
      // Clear audio levels once audio has been silent for at least the timeout
      elapsed = ev.now_time - last_audio_us;
      if (audio_heard_q && (audio_low_q != '0 || audio_high_q != '0) &&
          elapsed >= 32'(limits.audio_timeout)) begin
        audio_low_q  = '0;
        audio_high_q = '0;
        changed      = 1'b1;
        forced       = 1'b1;
      end
      if (ev.rumble_request) begin
        if (ev.rumble_low != game_low_q || ev.rumble_high != game_high_q) begin
          changed = 1'b1;
        end
        game_low_q  = ev.rumble_low;
        game_high_q = ev.rumble_high;
        forced      = 1'b1;
      end
    end

    if (!changed && !write_held_q) return 1'b0;

    want_low  = (game_low_q > audio_low_q) ? game_low_q : audio_low_q;
    want_high = (game_high_q > audio_high_q) ? game_high_q : audio_high_q;

    // Drop a repeat of the last write
    if (sent_any_q && sent_low_q == want_low && sent_high_q == want_high) begin
      write_held_q = 1'b0;
      return 1'b0;
    end

    // Hold an unforced write that is too soon or too small, unless it crosses zero
    if (!forced &&
        ((sent_low_q == '0 && sent_high_q == '0) == (want_low == '0 && want_high == '0))) begin
      elapsed    = ev.now_time - last_write_us;
      small_step = level_gap(sent_low_q, want_low) < limits.min_useful_delta &&
                   level_gap(sent_high_q, want_high) < limits.min_useful_delta;
      if (elapsed < 32'(limits.min_write_interval) ||
          (small_step && elapsed < 32'(limits.small_change_refresh))) begin
        write_held_q = 1'b1;
        return 1'b0;
      end
    end

    sent_low_q    = want_low;
    sent_high_q   = want_high;
    sent_any_q    = 1'b1;
    last_write_us = ev.now_time;
    write_held_q  = 1'b0;
    wr.write_low  = want_low;
    wr.write_high = want_high;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t predicted;
    res_t oldest;
    if (!rst_ni) begin
      limits.min_write_interval   = MIN_WRITE_INTERVAL_RST;
      limits.small_change_refresh = SMALL_CHANGE_REFRESH_RST;
      limits.min_useful_delta     = MIN_USEFUL_DELTA_RST;
      limits.audio_timeout        = AUDIO_TIMEOUT_RST;
      audio_low_q      = '0;
      audio_high_q     = '0;
      game_low_q       = '0;
      game_high_q      = '0;
      sent_low_q       = '0;
      sent_high_q      = '0;
      sent_any_q       = 1'b0;
      audio_heard_q    = 1'b0;
      write_held_q     = 1'b0;
      last_write_us    = '0;
      last_audio_us    = '0;
      expected_writes.delete();
      mismatch_count_o = 0;
      writes_due_o     = 0;
    end else begin
      // Compare a write transfer with the oldest prediction
      if (res_valid_i && res_ready_i) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none, actual %0d/%0d",
                   $time, res_i.write_low, res_i.write_high);
          mismatch_count_o++;
        end else begin
          oldest = expected_writes.pop_front();
          if (res_i.write_low !== oldest.write_low) begin
            $display("%0t: write_low mismatch, expected %0d, actual %0d",
                     $time, oldest.write_low, res_i.write_low);
            mismatch_count_o++;
          end
          if (res_i.write_high !== oldest.write_high) begin
            $display("%0t: write_high mismatch, expected %0d, actual %0d",
                     $time, oldest.write_high, res_i.write_high);
            mismatch_count_o++;
          end
        end
      end

      // Predict from an event transfer
      if (evt_valid_i && evt_ready_i) begin
        if (predict_motor_write(evt_i, predicted)) expected_writes.push_back(predicted);
      end

      // Track register writes; unknown indexes change nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_WRITE_INTERVAL:   limits.min_write_interval   = cfg_data_i[19:0];
          CFG_SMALL_CHANGE_REFRESH: limits.small_change_refresh = cfg_data_i[19:0];
          CFG_MIN_USEFUL_DELTA:     limits.min_useful_delta     = cfg_data_i[7:0];
          CFG_AUDIO_TIMEOUT:        limits.audio_timeout        = cfg_data_i[23:0];
          default: ;
        endcase
      end

      writes_due_o = expected_writes.size();
    end
  end

endmodule

// ----- tb/sv/tb_rumble_mix_rate_limiter_top.sv -----
`timescale 1ns / 1ps

module tb_rumble_mix_rate_limiter_top;
  import rmrl_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CfgIdxBeyond = CFG_AUDIO_TIMEOUT + 8'd1;
  localparam logic [CfgIdxWidth-1:0] CfgIdxTop    = '1;
  localparam int unsigned            ItemsPerPhase = 110;
  localparam int unsigned            LongHoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned writes_due;

  // Stimulus shaping, shared by the driving processes
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 57;
  int unsigned hold_request  = 0;
  int unsigned cur_interval  = 32'(MIN_WRITE_INTERVAL_RST);
  int unsigned cur_refresh   = 32'(SMALL_CHANGE_REFRESH_RST);
  int unsigned cur_delta     = 32'(MIN_USEFUL_DELTA_RST);
  int unsigned cur_timeout   = 32'(AUDIO_TIMEOUT_RST);

  rmrl_cfg_if                        cfg_if ();
  rmrl_stream_if #(.payload_t(evt_t)) evt_if ();
  rmrl_stream_if #(.payload_t(res_t)) res_if ();

  rumble_mix_rate_limiter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  rmrl_mix_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_index_i      (cfg_if.index),
    .cfg_data_i       (cfg_if.data),
    .evt_valid_i      (evt_if.valid),
    .evt_ready_i      (evt_if.ready),
    .evt_i            (evt_if.payload),
    .res_valid_i      (res_if.valid),
    .res_ready_i      (res_if.ready),
    .res_i            (res_if.payload),
    .mismatch_count_o (mismatches),
    .writes_due_o     (writes_due)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Give up on a run that hangs
  initial begin
    #5_000_000;
    $display("FAIL rumble_mix_rate_limiter_top");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when asked for
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic evt_t make_event(input op_e op, input logic [7:0] a_lo,
                                      input logic [7:0] a_hi, input logic req,
                                      input logic [7:0] r_lo, input logic [7:0] r_hi,
                                      input logic [31:0] stamp);
    evt_t ev;
    ev.operation      = op;
    ev.audio_low      = a_lo;
    ev.audio_high     = a_hi;
    ev.rumble_request = req;
    ev.rumble_low     = r_lo;
    ev.rumble_high    = r_hi;
    ev.now_time       = stamp;
    return ev;
  endfunction

  // Pick a next level: zero, full scale, the previous one, a small move around it or a random jump
  function automatic logic [7:0] next_level(input logic [7:0] prev);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 255;
      2: v = prev;
      3, 4: begin
        v = int'(prev) + int'($urandom_range(0, 2 * cur_delta + 2)) - int'(cur_delta + 1);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  // Offer one event after a random gap; return at the falling edge after its transfer
  task automatic send_event(input evt_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt_if.valid   <= 1'b1;
    evt_if.payload <= ev;
    do @(posedge clk_i); while (!evt_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_limits(input logic [CfgDataWidth-1:0] interval,
                                input logic [CfgDataWidth-1:0] refresh,
                                input logic [CfgDataWidth-1:0] delta,
                                input logic [CfgDataWidth-1:0] timeout);
    write_register(CFG_MIN_WRITE_INTERVAL, interval);
    write_register(CFG_SMALL_CHANGE_REFRESH, refresh);
    write_register(CFG_MIN_USEFUL_DELTA, delta);
    write_register(CFG_AUDIO_TIMEOUT, timeout);
    cur_interval = 32'(interval[19:0]);
    cur_refresh  = 32'(refresh[19:0]);
    cur_delta    = 32'(delta[7:0]);
    cur_timeout  = 32'(timeout);
  endtask

  // Stop offering and let every predicted write drain, plus the pipeline depth
  task automatic wait_for_quiet();
    evt_if.valid <= 1'b0;
    while (writes_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    evt_t        ev;
    logic [31:0] stamp_us;
    longint      step;
    logic [7:0]  aud_low;
    logic [7:0]  aud_high;
    logic [7:0]  game_low;
    logic [7:0]  game_high;
    int unsigned guard;
    aud_low        = '0;
    aud_high       = '0;
    game_low       = '0;
    game_high      = '0;
    stamp_us       = '0;
    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    evt_if.valid   = 1'b0;
    evt_if.payload = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed events under the reset limits
    // quiet report, then silent audio: nothing changes
    send_event(make_event(OP_OTHER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'd0));
    send_event(make_event(OP_AUDIO, 8'h00, 8'h00, 1'b1, 8'hFF, 8'hFF, 32'd10));
    // first write crosses zero, then a small early change is held
    send_event(make_event(OP_AUDIO, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 32'd20));
    send_event(make_event(OP_AUDIO, 8'hFE, 8'hFF, 1'b0, 8'h00, 8'h00, 32'd30));
    send_event(make_event(OP_OTHER, 8'h12, 8'h34, 1'b0, 8'h56, 8'h78, 32'd40));
    // held write goes out once the refresh time has passed
    send_event(make_event(OP_OTHER, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'd25030));
    send_event(make_event(OP_AUDIO, 8'hFE, 8'hFF, 1'b0, 8'h00, 8'h00, 32'd25040));
    // forced game rumble, mixed per motor with audio
    send_event(make_event(OP_OTHER, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h00, 32'd25050));
    send_event(make_event(OP_OTHER, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h00, 32'd25060));
    // audio falls to zero and is held back, then a forced zero rumble writes zeros
    send_event(make_event(OP_AUDIO, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'd25070));
    send_event(make_event(OP_OTHER, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 32'd25080));
    // zero crossings bypass the interval
    send_event(make_event(OP_AUDIO, 8'h0A, 8'h00, 1'b0, 8'h00, 8'h00, 32'd25090));
    send_event(make_event(OP_AUDIO, 8'h64, 8'hC8, 1'b0, 8'h00, 8'h00, 32'd25100));
    send_event(make_event(OP_AUDIO, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'd25110));
    send_event(make_event(OP_AUDIO, 8'h32, 8'h3C, 1'b0, 8'h00, 8'h00, 32'd26000));
    // audio silent exactly for the timeout is cleared
    send_event(make_event(OP_OTHER, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'hFF, 32'd126000));
    // timestamps wrapping round
    send_event(make_event(OP_AUDIO, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 32'hFFFF_FFF0));
    send_event(make_event(OP_AUDIO, 8'hC8, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0000_0100));
    send_event(make_event(OP_AUDIO, 8'hC8, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0000_1390));
    send_event(make_event(OP_OTHER, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 32'h0000_1400));
    send_event(make_event(OP_OTHER, 8'hAA, 8'h55, 1'b1, 8'h00, 8'h00, 32'hFFFF_FFFF));
    send_event(make_event(OP_AUDIO, 8'h01, 8'h01, 1'b1, 8'hFF, 8'hFF, 32'h0000_0005));
    stamp_us = 32'h0000_0005;
    aud_low  = 8'h01;
    aud_high = 8'h01;

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      wait_for_quiet();
      case (phase)
        0: program_limits(24'($urandom_range(50, 2000)), 24'($urandom_range(500, 20000)),
                          24'($urandom_range(1, 16)), 24'($urandom_range(1000, 60000)));
        1: program_limits('0, '0, '0, '0);
        2: begin
          // all ones: the wide data is cut to each register width
          program_limits('1, '1, '1, '1);
          write_register(CfgIdxBeyond, 24'($urandom));
          write_register(CfgIdxTop, 24'($urandom));
        end
        3: program_limits(24'($urandom_range(0, 300)), 24'($urandom_range(0, 3000)),
                          24'($urandom_range(0, 255)), 24'($urandom_range(0, 5000)));
        default: program_limits(24'(MIN_WRITE_INTERVAL_RST), 24'(SMALL_CHANGE_REFRESH_RST),
                                24'(MIN_USEFUL_DELTA_RST), 24'(AUDIO_TIMEOUT_RST));
      endcase
      send_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 57 : 0;
      recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 23 : 0;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Advance the timestamp on the scale of the current limits
        case ($urandom_range(0, 11))
          0: step = 0;
          1, 2, 3: step = longint'($urandom_range(0, cur_interval));
          4, 5: step = longint'(cur_interval) + longint'($urandom_range(0, cur_interval));
          6, 7: step = longint'($urandom_range(cur_interval, cur_refresh + 10));
          8: begin
            step = longint'(cur_timeout) + longint'($urandom_range(0, 2)) - 1;
            if (step < 0) step = 0;
          end
          9: step = longint'($urandom);
          default: step = longint'($urandom_range(1, 40));
        endcase
        stamp_us = stamp_us + 32'(step);

        // Unused fields carry noise
        ev.operation      = ($urandom_range(0, 9) < 6) ? OP_AUDIO : OP_OTHER;
        ev.audio_low      = 8'($urandom);
        ev.audio_high     = 8'($urandom);
        ev.rumble_request = 1'b0;
        ev.rumble_low     = 8'($urandom);
        ev.rumble_high    = 8'($urandom);
        ev.now_time       = stamp_us;
        if (ev.operation == OP_AUDIO) begin
          aud_low       = next_level(aud_low);
          aud_high      = next_level(aud_high);
          ev.audio_low  = aud_low;
          ev.audio_high = aud_high;
        end else if ($urandom_range(0, 1) == 1) begin
          game_low          = next_level(game_low);
          game_high         = next_level(game_high);
          ev.rumble_request = 1'b1;
          ev.rumble_low     = game_low;
          ev.rumble_high    = game_high;
        end
        send_event(ev);

        // Hold off the receiver for long while events keep coming
        if (phase == 4 && n == 20) hold_request = LongHoldCycles;
      end
    end

    // Drain and give the verdict
    evt_if.valid <= 1'b0;
    guard = 0;
    while (writes_due != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (writes_due != 0) begin
      $display("%0t: %0d expected writes never arrived", $time, writes_due);
    end
    if (mismatches == 0 && writes_due == 0) begin
      $display("PASS rumble_mix_rate_limiter_top");
    end else begin
      $display("FAIL rumble_mix_rate_limiter_top");
    end
    $finish;
  end

endmodule
